>>> rtl/core/stbs_pkg.sv
`timescale 1ns / 1ps
// stbs_pkg: shared constants, codes and control types for the sorted table bound search
// no dependencies; used by the interfaces, controller, datapath and top level

package stbs_pkg;

  localparam int DEPTH      = 1024;
  localparam int VALUE_BITS = 20;
  localparam int ADDR_BITS  = $clog2(DEPTH);
  localparam int CNT_BITS   = ADDR_BITS + 1;
  localparam int POS_BITS   = 11;
  localparam int IDX_BITS   = CNT_BITS + 1;
  localparam int OP_BITS    = 2;

  typedef enum logic [OP_BITS-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MODE_FIRST = 2'd0,
    MODE_LAST  = 2'd1,
    MODE_LOWER = 2'd2,
    MODE_UPPER = 2'd3
  } search_mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADDR,
    ST_CMP,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic clear;
    logic append;
    logic query_start;
    logic probe_read;
    logic probe_update;
    logic finish_search;
    logic load_result;
  } cmd_t;

  typedef struct packed {
    logic loop_ok;
    logic last_mode;
    logic out_free;
  } status_t;

endpackage

>>> rtl/core/stbs_in_if.sv
`timescale 1ns / 1ps
// stbs_in_if: request channel carrying an operation code and a value
// depends on stbs_pkg for field widths

interface stbs_in_if;
  logic                            valid;
  logic                            ready;
  logic [stbs_pkg::OP_BITS-1:0]    operation;
  logic [stbs_pkg::VALUE_BITS-1:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink (input valid, input operation, input value, output ready);
endinterface

>>> rtl/core/stbs_out_if.sv
`timescale 1ns / 1ps
// stbs_out_if: result channel carrying the four positions and the match count
// depends on stbs_pkg for field widths

interface stbs_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [stbs_pkg::POS_BITS-1:0] first_pos;
  logic signed [stbs_pkg::POS_BITS-1:0] last_pos;
  logic signed [stbs_pkg::POS_BITS-1:0] lower_pos;
  logic signed [stbs_pkg::POS_BITS-1:0] upper_pos;
  logic [stbs_pkg::CNT_BITS-1:0]        match_count;

  modport source (output valid, output first_pos, output last_pos, output lower_pos,
                  output upper_pos, output match_count, input ready);
  modport sink (input valid, input first_pos, input last_pos, input lower_pos,
                input upper_pos, input match_count, output ready);
endinterface

>>> rtl/core/stbs_ctrl.sv
`timescale 1ns / 1ps
// stbs_ctrl: sequencing state machine for table updates and the four searches
// depends on stbs_pkg for state, command and status types

module stbs_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [stbs_pkg::OP_BITS-1:0] operation,
  output logic                         in_ready,
  input  stbs_pkg::status_t            status,
  output stbs_pkg::cmd_t               cmd
);

  stbs_pkg::state_t state, state_next;
  logic             accept;

  assign in_ready = (state == stbs_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stbs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      stbs_pkg::ST_IDLE: begin
        if (accept && operation == stbs_pkg::OP_QUERY) begin
          state_next = stbs_pkg::ST_ADDR;
        end
      end
      stbs_pkg::ST_ADDR: begin
        if (status.loop_ok) begin
          state_next = stbs_pkg::ST_CMP;
        end else if (status.last_mode) begin
          state_next = stbs_pkg::ST_RESULT;
        end
      end
      stbs_pkg::ST_CMP: begin
        state_next = stbs_pkg::ST_ADDR;
      end
      stbs_pkg::ST_RESULT: begin
        if (status.out_free) begin
          state_next = stbs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = stbs_pkg::ST_IDLE;
      end
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    case (state)
      stbs_pkg::ST_IDLE: begin
        cmd.clear       = accept && operation == stbs_pkg::OP_CLEAR;
        cmd.append      = accept && operation == stbs_pkg::OP_APPEND;
        cmd.query_start = accept && operation == stbs_pkg::OP_QUERY;
      end
      stbs_pkg::ST_ADDR: begin
        cmd.probe_read    = status.loop_ok;
        cmd.finish_search = !status.loop_ok;
      end
      stbs_pkg::ST_CMP: begin
        cmd.probe_update = 1'b1;
      end
      stbs_pkg::ST_RESULT: begin
        cmd.load_result = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    state == stbs_pkg::ST_CMP |-> $past(state) == stbs_pkg::ST_ADDR)
    else $error("compare step without a preceding table read");
  assert property (@(posedge clk) disable iff (rst)
    cmd.query_start |=> state == stbs_pkg::ST_ADDR)
    else $error("query did not start the first search");
  assert property (@(posedge clk) disable iff (rst)
    state == stbs_pkg::ST_RESULT && status.out_free |=> in_ready)
    else $error("controller did not return to idle after result");

endmodule

>>> rtl/core/stbs_datapath.sv
`timescale 1ns / 1ps
// stbs_datapath: value table memory, element count, search bounds and result register
// depends on stbs_pkg for widths, search modes and command and status types

module stbs_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  stbs_pkg::cmd_t                        cmd,
  output stbs_pkg::status_t                     status,
  input  logic [stbs_pkg::VALUE_BITS-1:0]       value,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output logic signed [stbs_pkg::POS_BITS-1:0]  first_pos,
  output logic signed [stbs_pkg::POS_BITS-1:0]  last_pos,
  output logic signed [stbs_pkg::POS_BITS-1:0]  lower_pos,
  output logic signed [stbs_pkg::POS_BITS-1:0]  upper_pos,
  output logic [stbs_pkg::CNT_BITS-1:0]         match_count
);

  localparam int IB = stbs_pkg::IDX_BITS;
  localparam int PB = stbs_pkg::POS_BITS;

  logic [stbs_pkg::VALUE_BITS-1:0] mem [stbs_pkg::DEPTH];
  logic [stbs_pkg::VALUE_BITS-1:0] rd_data;
  logic [stbs_pkg::CNT_BITS-1:0]   count;
  logic [stbs_pkg::VALUE_BITS-1:0] key;
  stbs_pkg::search_mode_t          mode;
  logic signed [IB-1:0]            left;
  logic signed [IB-1:0]            right;
  logic signed [PB-1:0]            found;
  logic signed [PB-1:0]            res_first, res_last, res_lower, res_upper;

  logic signed [IB:0]              mid_sum;
  logic signed [IB-1:0]            mid;
  logic                            hit, go_left;
  logic signed [PB:0]              span;
  logic                            count_ok;

  assign mid_sum = {left[IB-1], left} + {right[IB-1], right};
  assign mid     = mid_sum[IB:1];

  assign status.loop_ok   = (left <= right);
  assign status.last_mode = (mode == stbs_pkg::MODE_UPPER);
  assign status.out_free  = !out_valid || out_ready;

  // probe decision against the registered table word
  always_comb begin
    case (mode)
      stbs_pkg::MODE_FIRST: begin
        hit     = (rd_data == key);
        go_left = (rd_data >= key);
      end
      stbs_pkg::MODE_LAST: begin
        hit     = (rd_data == key);
        go_left = (rd_data > key);
      end
      stbs_pkg::MODE_LOWER: begin
        hit     = (rd_data >= key);
        go_left = hit;
      end
      stbs_pkg::MODE_UPPER: begin
        hit     = (rd_data > key);
        go_left = hit;
      end
      default: begin
        hit     = 1'b0;
        go_left = 1'b0;
      end
    endcase
  end

  // table memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.append && count < stbs_pkg::CNT_BITS'(stbs_pkg::DEPTH)) begin
      mem[count[stbs_pkg::ADDR_BITS-1:0]] <= value;
    end
    if (cmd.probe_read) begin
      rd_data <= mem[mid[stbs_pkg::ADDR_BITS-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clear) begin
      count <= '0;
    end else if (cmd.append && count < stbs_pkg::CNT_BITS'(stbs_pkg::DEPTH)) begin
      count <= count + stbs_pkg::CNT_BITS'(1);
    end
  end

  // search bounds and found positions
  always_ff @(posedge clk) begin
    if (cmd.query_start) begin
      key   <= value;
      mode  <= stbs_pkg::MODE_FIRST;
      left  <= '0;
      right <= $signed({1'b0, count}) - IB'(1);
      found <= '1;
    end else if (cmd.probe_update) begin
      if (hit) begin
        found <= mid[PB-1:0];
      end
      if (go_left) begin
        right <= mid - IB'(1);
      end else begin
        left <= mid + IB'(1);
      end
    end else if (cmd.finish_search) begin
      left  <= '0;
      right <= $signed({1'b0, count}) - IB'(1);
      found <= '1;
      case (mode)
        stbs_pkg::MODE_FIRST: begin
          res_first <= found;
          mode      <= stbs_pkg::MODE_LAST;
        end
        stbs_pkg::MODE_LAST: begin
          res_last <= found;
          mode     <= stbs_pkg::MODE_LOWER;
        end
        stbs_pkg::MODE_LOWER: begin
          res_lower <= found;
          mode      <= stbs_pkg::MODE_UPPER;
        end
        stbs_pkg::MODE_UPPER: begin
          res_upper <= found;
        end
        default: begin
          mode <= stbs_pkg::MODE_FIRST;
        end
      endcase
    end
  end

  assign span     = {res_last[PB-1], res_last} - {res_first[PB-1], res_first} + (PB+1)'(1);
  assign count_ok = !res_first[PB-1] && !res_last[PB-1] && (res_last >= res_first);

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      first_pos   <= res_first;
      last_pos    <= res_last;
      lower_pos   <= res_lower;
      upper_pos   <= res_upper;
      match_count <= count_ok ? span[stbs_pkg::CNT_BITS-1:0] : '0;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    count <= stbs_pkg::CNT_BITS'(stbs_pkg::DEPTH))
    else $error("element count beyond table depth");
  assert property (@(posedge clk) disable iff (rst)
    cmd.probe_read |-> !mid[IB-1] && (mid < $signed({1'b0, count})))
    else $error("probe outside the filled part of the table");
  assert property (@(posedge clk) disable iff (rst)
    cmd.probe_update |-> $past(cmd.probe_read))
    else $error("table word used without a read");
  assert property (@(posedge clk) disable iff (rst)
    cmd.load_result |=> out_valid)
    else $error("result lost on load");

endmodule

>>> rtl/core/sorted_table_bound_search.sv
`timescale 1ns / 1ps
// sorted_table_bound_search: top level joining controller, datapath and the two channels
// depends on stbs_pkg, stbs_in_if, stbs_out_if, stbs_ctrl and stbs_datapath

// The block keeps a table of up to 1024 values of 20 bits, filled in order by append
// requests and emptied by a clear request. A query request runs four binary searches over
// the filled entries with midpoint (left+right)/2 (first equal, last equal, first at least
// the key, first above the key) and returns one result with the four positions, -1 where
// none exists, plus the count of equal entries. Operation code 3 is accepted and ignored.
// A search makes at most 11 probes for a full table; each probe reads the registered table
// memory in state ADDR and then compares and narrows the bounds in state CMP, and
// the searches run one after another on that one read port. One request is in flight at a
// time; a finished result sits in an output register while the next request is taken.

module sorted_table_bound_search (
  input  logic              clk,
  input  logic              rst,
  stbs_in_if.sink           in_ch,
  stbs_out_if.source        out_ch
);

  stbs_pkg::cmd_t    cmd;
  stbs_pkg::status_t status;

  // sequencing: idle accept, probe read, probe compare, result hand-off
  stbs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .operation (in_ch.operation),
    .in_ready  (in_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // table memory, search bounds and the result register
  stbs_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .value       (in_ch.value),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .first_pos   (out_ch.first_pos),
    .last_pos    (out_ch.last_pos),
    .lower_pos   (out_ch.lower_pos),
    .upper_pos   (out_ch.upper_pos),
    .match_count (out_ch.match_count)
  );

endmodule

>>> sim/sorted_table_bound_search_tb.sv
`timescale 1ns / 1ps
// sorted_table_bound_search_tb: self-checking bench for the sorted table bound search block
// depends on stbs_pkg, stbs_in_if, stbs_out_if and the sorted_table_bound_search rtl

module sorted_table_bound_search_tb;

  localparam int VALUE_MAX = (1 << stbs_pkg::VALUE_BITS) - 1;
  localparam int AB        = stbs_pkg::ADDR_BITS;

  typedef bit [stbs_pkg::VALUE_BITS-1:0] value_t;

  // one query result as signed positions and an unsigned count
  typedef struct {
    int first_pos;
    int last_pos;
    int lower_pos;
    int upper_pos;
    int match_count;
  } bound_result_t;

  // keeps its own copy of the table, predicts each query outcome and
  // compares it against the results the block hands back, in order
  class bound_scoreboard;
    value_t              entries [stbs_pkg::DEPTH];
    int                  fill;
    bound_result_t       awaited_q [$];
    int                  failures;

    function new();
      fill = 0;
      failures = 0;
    endfunction

    // binary search, midpoint (left+right)/2, over whatever is stored
    function int bound_search(value_t key, stbs_pkg::search_mode_t mode);
      int left;
      int right;
      int mid;
      int found;
      bit hit;
      bit go_left;
      value_t e;
      left = 0;
      right = fill - 1;
      found = -1;
      while (left <= right) begin
        mid = (left + right) / 2;
        e = entries[mid[AB-1:0]];
        case (mode)
          stbs_pkg::MODE_FIRST: begin
            hit = (e == key);
            go_left = (e >= key);
          end
          stbs_pkg::MODE_LAST: begin
            hit = (e == key);
            go_left = (e > key);
          end
          stbs_pkg::MODE_LOWER: begin
            hit = (e >= key);
            go_left = hit;
          end
          default: begin
            hit = (e > key);
            go_left = hit;
          end
        endcase
        if (hit) found = mid;
        if (go_left) right = mid - 1;
        else left = mid + 1;
      end
      return found;
    endfunction

    // called for every accepted request
    function void note_request(stbs_pkg::op_t op, value_t val);
      bound_result_t r;
      case (op)
        stbs_pkg::OP_CLEAR: fill = 0;
        stbs_pkg::OP_APPEND: begin
          if (fill < stbs_pkg::DEPTH) begin
            entries[fill[AB-1:0]] = val;
            fill++;
          end
        end
        stbs_pkg::OP_QUERY: begin
          r.first_pos = bound_search(val, stbs_pkg::MODE_FIRST);
          r.last_pos  = bound_search(val, stbs_pkg::MODE_LAST);
          r.lower_pos = bound_search(val, stbs_pkg::MODE_LOWER);
          r.upper_pos = bound_search(val, stbs_pkg::MODE_UPPER);
          if (r.first_pos >= 0 && r.last_pos >= 0 && r.last_pos >= r.first_pos)
            r.match_count = r.last_pos - r.first_pos + 1;
          else
            r.match_count = 0;
          awaited_q.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void check_field(string name, int want, int got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        failures++;
      end
    endfunction

    function void check_result(bound_result_t got);
      bound_result_t want;
      if (awaited_q.size() == 0) begin
        $error("result arrived with no query outstanding");
        failures++;
        return;
      end
      want = awaited_q.pop_front();
      check_field("first_pos", want.first_pos, got.first_pos);
      check_field("last_pos", want.last_pos, got.last_pos);
      check_field("lower_pos", want.lower_pos, got.lower_pos);
      check_field("upper_pos", want.upper_pos, got.upper_pos);
      check_field("match_count", want.match_count, got.match_count);
    endfunction

    function int pending();
      return awaited_q.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  stbs_in_if  in_ch ();
  stbs_out_if out_ch ();

  sorted_table_bound_search dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  bound_scoreboard book = new();

  // idling knobs, changed per phase by the stimulus process
  int src_idle_pct  = 0;
  int sink_stall_pct = 0;
  bit long_hold_go  = 0;
  int requests_sent = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // generous hard stop, far beyond the slowest legal run
  initial begin
    #12_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off counted here so that the
  // output register and the in-flight query back up and the input stalls
  initial begin
    int hold_left;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (long_hold_go) begin
        long_hold_go = 0;
        hold_left = 1500;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // result monitor, sampled at the rising edge
  always @(posedge clk) begin
    bound_result_t got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.first_pos   = int'(out_ch.first_pos);
      got.last_pos    = int'(out_ch.last_pos);
      got.lower_pos   = int'(out_ch.lower_pos);
      got.upper_pos   = int'(out_ch.upper_pos);
      got.match_count = int'(out_ch.match_count);
      book.check_result(got);
    end
  end

  // offer one request, with random gaps ahead of it, and wait for the handshake;
  // valid is left high so a following request can go back to back
  task automatic send_request(stbs_pkg::op_t op, value_t val);
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.value     <= val;
    do @(posedge clk); while (!in_ch.ready);
    book.note_request(op, val);
    if (op != stbs_pkg::OP_NONE) requests_sent++;
  endtask

  // key picker: stored values half the time, else neighbours, the two extremes or anywhere
  function automatic value_t pick_key(ref int vals [$]);
    int k;
    int sel;
    sel = $urandom_range(9);
    if (vals.size() == 0 || sel == 7) return value_t'($urandom_range(0, VALUE_MAX));
    k = vals[$urandom_range(vals.size() - 1)];
    case (sel)
      5: k = (k == 0) ? 0 : k - 1;
      6: k = (k == VALUE_MAX) ? VALUE_MAX : k + 1;
      8: k = 0;
      9: k = VALUE_MAX;
      default: ;
    endcase
    return value_t'(k);
  endfunction

  // one random sequence: optional clear, an ascending run of appends with
  // random step sizes, then a batch of queries; noisy runs break the order
  // and slip in the unused operation code
  task automatic run_sequence(int n_append, int max_step, int n_query, bit do_clear,
                              bit noisy, bit with_hold);
    int vals [$];
    int v;
    int lim;
    if (do_clear) send_request(stbs_pkg::OP_CLEAR, value_t'($urandom_range(0, VALUE_MAX)));
    lim = VALUE_MAX - n_append * max_step;
    if (lim < 0) lim = 0;
    v = $urandom_range(0, lim);
    for (int i = 0; i < n_append; i++) begin
      if (noisy && $urandom_range(19) == 0)
        send_request(stbs_pkg::OP_NONE, value_t'($urandom_range(0, VALUE_MAX)));
      if (noisy && $urandom_range(9) == 0) begin
        lim = $urandom_range(0, VALUE_MAX);
        vals.push_back(lim);
        send_request(stbs_pkg::OP_APPEND, value_t'(lim));
      end else begin
        vals.push_back(v);
        send_request(stbs_pkg::OP_APPEND, value_t'(v));
        v += $urandom_range(0, max_step);
        if (v > VALUE_MAX) v = VALUE_MAX;
      end
    end
    if (with_hold) long_hold_go = 1;
    for (int i = 0; i < n_query; i++) send_request(stbs_pkg::OP_QUERY, pick_key(vals));
  endtask

  initial begin
    int seq_no;
    int phase;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.operation = stbs_pkg::OP_CLEAR;
    in_ch.value = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty table, the unused code, duplicates at the start and in
    // the middle, keys absent between entries, below and above the table,
    // an out-of-order append, and a clear followed by queries
    send_request(stbs_pkg::OP_QUERY, value_t'(0));
    send_request(stbs_pkg::OP_NONE, value_t'(VALUE_MAX));
    send_request(stbs_pkg::OP_APPEND, value_t'(0));
    send_request(stbs_pkg::OP_APPEND, value_t'(0));
    send_request(stbs_pkg::OP_APPEND, value_t'(5));
    send_request(stbs_pkg::OP_APPEND, value_t'(5));
    send_request(stbs_pkg::OP_APPEND, value_t'(5));
    send_request(stbs_pkg::OP_APPEND, value_t'(VALUE_MAX - 1));
    send_request(stbs_pkg::OP_APPEND, value_t'(VALUE_MAX));
    send_request(stbs_pkg::OP_QUERY, value_t'(0));
    send_request(stbs_pkg::OP_QUERY, value_t'(5));
    send_request(stbs_pkg::OP_QUERY, value_t'(3));
    send_request(stbs_pkg::OP_QUERY, value_t'(VALUE_MAX));
    send_request(stbs_pkg::OP_QUERY, value_t'(VALUE_MAX - 1));
    send_request(stbs_pkg::OP_QUERY, value_t'(6));
    send_request(stbs_pkg::OP_NONE, value_t'(5));
    send_request(stbs_pkg::OP_APPEND, value_t'(2));
    send_request(stbs_pkg::OP_QUERY, value_t'(2));
    send_request(stbs_pkg::OP_QUERY, value_t'(5));
    send_request(stbs_pkg::OP_CLEAR, value_t'(VALUE_MAX));
    send_request(stbs_pkg::OP_QUERY, value_t'(5));
    send_request(stbs_pkg::OP_APPEND, 20'hABCDE);
    send_request(stbs_pkg::OP_QUERY, 20'hABCDE);
    send_request(stbs_pkg::OP_QUERY, value_t'(0));
    send_request(stbs_pkg::OP_QUERY, value_t'(VALUE_MAX));

    // random part, idling phase rotates each sequence
    seq_no = 0;
    while (requests_sent < 1450) begin
      phase = seq_no % 4;
      src_idle_pct   = (phase == 1) ? 58 : (phase == 3) ? 10 : 0;
      sink_stall_pct = (phase == 2) ? 58 : (phase == 3) ? 10 : 0;
      if (seq_no == 2)
        // fill the table to the brim; the last four appends are dropped
        run_sequence(stbs_pkg::DEPTH + 4, 900, 20, 1'b1, 1'b0, 1'b0);
      else if (seq_no == 5)
        run_sequence($urandom_range(4, 20), 3, 12, 1'b1, 1'b0, 1'b1);
      else
        run_sequence($urandom_range(0, 24), ($urandom_range(1) == 1) ? 2 : 40000,
                     $urandom_range(2, 8), ($urandom_range(99) < 85),
                     ($urandom_range(99) < 20), 1'b0);
      seq_no++;
    end
    @(negedge clk);
    in_ch.valid <= 1'b0;

    // drain, then allow for the longest query before judging
    while (book.pending() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (book.failures == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/stbs_pkg.sv
rtl/core/stbs_in_if.sv
rtl/core/stbs_out_if.sv
rtl/core/stbs_ctrl.sv
rtl/core/stbs_datapath.sv
rtl/core/sorted_table_bound_search.sv
sim/sorted_table_bound_search_tb.sv
